FILE: hdl/sbhf_pkg.sv
// Shared constants, types and helper functions for the half-block sprite blitter.
// Depends on nothing; used by the blitter top level.
package sbhf_pkg;

   localparam int SCREEN_W   = 128;
   localparam int SCREEN_H   = 128;
   localparam int MAX_SPRITE = 64;

   localparam int CELL_COUNT = SCREEN_W * ((SCREEN_H + 1) / 2);
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(MAX_SPRITE);
   localparam int SZ_W       = $clog2(MAX_SPRITE + 1);
   localparam int PX_W       = 11;
   localparam int IDX_W      = 17;
   localparam int CELL_W     = 8;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic signed [8:0] x;
      logic signed [8:0] y;
      logic [6:0]        w;
      logic [6:0]        h;
      logic              mh;
      logic              mv;
   } geometry_type;

   // Sizes of zero behave as one, sizes above the limit behave as the limit.
   function automatic logic [SZ_W-1:0] clamp_size(input logic [6:0] s);
      logic [SZ_W-1:0] r;
      if (s == 7'd0) begin
         r = SZ_W'(1);
      end else if (32'(s) > MAX_SPRITE) begin
         r = SZ_W'(MAX_SPRITE);
      end else begin
         r = SZ_W'(s);
      end
      return r;
   endfunction

endpackage

FILE: hdl/sbhf_ram.sv
// Generic single-clock RAM: one write port and one read port with registered read data.
// Depends on nothing.
module sbhf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/sprite_blit_halfblock_framebuffer.sv
// Sprite blitter into a half-block framebuffer (two stacked pixels per cell).
// The result strobe rises in the cycle after a request transfer. Read-modify-write goes
// through one cell RAM port pair. Throughput: one request per cycle while busy is low.
// Reset: a clearing pass writes color 0 to every one of the CELL_COUNT (8192) cells, one
// cell per cycle, while busy is high; csr writes are accepted throughout.
// The receiver cannot stall: each result appears for exactly one cycle.
module sprite_blit_halfblock_framebuffer (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic        req_first_pixel,
   input  logic signed [8:0] req_sprite_x,
   input  logic signed [8:0] req_sprite_y,
   input  logic [6:0]  req_sprite_w,
   input  logic [6:0]  req_sprite_h,
   input  logic        req_mirror_h,
   input  logic        req_mirror_v,
   input  logic [3:0]  req_pixel_color,
   input  logic [12:0] req_read_index,
   // Result channel.
   output logic        rsp_valid,
   output logic        rsp_written,
   output logic [3:0]  rsp_top_color,
   output logic [3:0]  rsp_bottom_color,
   // Configuration channel: transparent key.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);
   import sbhf_pkg::*;

   // Transparent key register. The port never pushes back.
   logic [3:0] key_ff, key_in;

   // Clearing pass after reset.
   logic               clr_busy_ff, clr_busy_in;
   logic [CELL_AW-1:0] clr_addr_ff, clr_addr_in;

   // Sprite geometry and walking counters.
   geometry_type     geom_ff, geom_in, geom_eff;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;

   // Stage one: the request whose cell data is coming out of the RAM.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_read_ff, s1_read_in;
   logic               s1_in_range_ff, s1_in_range_in;
   logic               s1_wr_ff, s1_wr_in;
   logic               s1_odd_ff, s1_odd_in;
   logic [3:0]         s1_color_ff, s1_color_in;
   logic [CELL_AW-1:0] s1_addr_ff, s1_addr_in;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [CELL_W-1:0]  fwd_data_ff, fwd_data_in;

   // Request decode.
   logic                   accept;
   logic [SZ_W-1:0]        w_cl, h_cl, colc, rowc, dx, dy, col1, row1;
   logic [CNT_W-1:0]       col_eff, row_eff;
   logic signed [PX_W-1:0] px, py;
   logic                   on_screen;
   logic [CELL_AW-1:0]     pix_cell, rd_addr;

   // Cell merge and RAM ports.
   logic [CELL_W-1:0]  ram_rdata, old_cell, new_cell, ram_wdata;
   logic [CELL_W-1:0]  zero_cell;
   logic [CELL_AW-1:0] ram_waddr;
   logic               ram_we;

   assign zero_cell = '0;
   assign csr_ready = 1'b1;
   assign busy      = clr_busy_ff;
   assign accept    = start && !clr_busy_ff;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         key_in = csr_data;
      end
   end

   // The clearing pass walks every cell once and then lets requests in.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + CELL_AW'(1);
         if (clr_addr_ff == CELL_AW'(CELL_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // A first pixel takes its geometry from the request and starts the walk at
   // the top-left corner; every other pixel uses the latched geometry.
   always_comb begin
      if (req_first_pixel) begin
         geom_eff.x  = req_sprite_x;
         geom_eff.y  = req_sprite_y;
         geom_eff.w  = req_sprite_w;
         geom_eff.h  = req_sprite_h;
         geom_eff.mh = req_mirror_h;
         geom_eff.mv = req_mirror_v;
         col_eff     = '0;
         row_eff     = '0;
      end else begin
         geom_eff = geom_ff;
         col_eff  = col_ff;
         row_eff  = row_ff;
      end

      w_cl = clamp_size(geom_eff.w);
      h_cl = clamp_size(geom_eff.h);
      colc = (SZ_W'(col_eff) >= w_cl) ? '0 : SZ_W'(col_eff);
      rowc = (SZ_W'(row_eff) >= h_cl) ? '0 : SZ_W'(row_eff);
      dx   = geom_eff.mh ? (w_cl - SZ_W'(1) - colc) : colc;
      dy   = geom_eff.mv ? (h_cl - SZ_W'(1) - rowc) : rowc;

      px = PX_W'(geom_eff.x) + $signed(PX_W'(dx));
      py = PX_W'(geom_eff.y) + $signed(PX_W'(dy));

      on_screen = !px[PX_W-1] && (32'(px[PX_W-2:0]) < SCREEN_W) &&
                  !py[PX_W-1] && (32'(py[PX_W-2:0]) < SCREEN_H);

      // An on-screen pixel always lands inside the framebuffer.
      pix_cell = CELL_AW'(px[7:0]) + CELL_AW'(CELL_AW'(SCREEN_W) * CELL_AW'(py[8:1]));
      rd_addr  = (req_type == REQ_READ) ? CELL_AW'(req_read_index) : pix_cell;

      // Counter advance: the column wraps into the next row, the row wraps to the top.
      col1 = colc + SZ_W'(1);
      row1 = rowc + SZ_W'(1);
   end

   always_comb begin
      geom_in = geom_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept && req_type == REQ_WRITE) begin
         if (req_first_pixel) begin
            geom_in = geom_eff;
         end
         if (col1 >= w_cl) begin
            col_in = '0;
            row_in = (row1 >= h_cl) ? '0 : CNT_W'(row1);
         end else begin
            col_in = CNT_W'(col1);
            row_in = CNT_W'(rowc);
         end
      end
   end

   // The cell read for stage one may be the one that the previous request was
   // writing in the cycle the read was issued; that case takes the forwarded value.
   always_comb begin
      old_cell = fwd_hit_ff ? fwd_data_ff : ram_rdata;
      if (s1_odd_ff) begin
         new_cell = {old_cell[7:4], s1_color_ff};
      end else begin
         new_cell = {s1_color_ff, old_cell[3:0]};
      end

      if (clr_busy_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = zero_cell;
      end else begin
         ram_we    = s1_valid_ff && s1_wr_ff;
         ram_waddr = s1_addr_ff;
         ram_wdata = new_cell;
      end
   end

   always_comb begin
      s1_valid_in    = accept;
      s1_read_in     = req_type == REQ_READ;
      s1_in_range_in = IDX_W'(req_read_index) < IDX_W'(CELL_COUNT);
      s1_wr_in       = (req_type == REQ_WRITE) && on_screen && (req_pixel_color != key_ff);
      s1_odd_in      = py[0];
      s1_color_in    = req_pixel_color;
      s1_addr_in     = rd_addr;
      fwd_hit_in     = s1_valid_ff && s1_wr_ff && (s1_addr_ff == rd_addr);
      fwd_data_in    = new_cell;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         geom_ff     <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         key_ff      <= key_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         geom_ff     <= geom_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff     <= s1_read_in;
      s1_in_range_ff <= s1_in_range_in;
      s1_wr_ff       <= s1_wr_in;
      s1_odd_ff      <= s1_odd_in;
      s1_color_ff    <= s1_color_in;
      s1_addr_ff     <= s1_addr_in;
      fwd_hit_ff     <= fwd_hit_in;
      fwd_data_ff    <= fwd_data_in;
   end

   sbhf_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_cells (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   // Results: a write reports whether it stored, a read both colors or zeros if out of range.
   always_comb begin
      rsp_valid        = s1_valid_ff;
      rsp_written      = s1_valid_ff && !s1_read_ff && s1_wr_ff;
      rsp_top_color    = '0;
      rsp_bottom_color = '0;
      if (s1_valid_ff && s1_read_ff && s1_in_range_ff) begin
         rsp_top_color    = old_cell[7:4];
         rsp_bottom_color = old_cell[3:0];
      end
   end

`ifndef SYNTHESIS
   a_rsp_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result strobe without a request transfer one cycle earlier");

   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !clr_busy_ff)
      else $error("request in flight during the clearing pass");

   a_write_result_has_no_colors: assert property (@(posedge clock) disable iff (reset)
      rsp_written |-> (rsp_top_color == 4'd0 && rsp_bottom_color == 4'd0))
      else $error("stored pixel result carries read colors");

   a_counters_inside_sprite: assert property (@(posedge clock) disable iff (reset)
      SZ_W'(col_ff) < clamp_size(geom_ff.w) && SZ_W'(row_ff) < clamp_size(geom_ff.h))
      else $error("walk counters outside the latched sprite size");
`endif

endmodule

FILE: bench/sprite_blit_halfblock_framebuffer_tb.sv
// Self-checking bench for the half-block sprite blitter: random and directed sprites and reads.
// It keeps its own framebuffer predictor and needs only sbhf_pkg and the blitter RTL.
module sprite_blit_halfblock_framebuffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbhf_pkg::*;

   // Watchdog: the slowest correct run is the reset, the clearing pass of every cell,
   // and about 1400 transfers with random gaps between them. That is far below
   // CYCLE_LIMIT, so this limit leaves a wide margin.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int REPORT_MAX  = 10;

   // One request as the sender sees it. Every field is kept, even the ones the
   // block ignores for this kind of request, so junk in them gets exercised too.
   typedef struct {
      logic              kind;
      logic              first;
      logic signed [8:0] x;
      logic signed [8:0] y;
      logic [6:0]        w;
      logic [6:0]        h;
      logic              mh;
      logic              mv;
      logic [3:0]        color;
      logic [12:0]       index;
   } blit_req_type;

   typedef struct {
      logic       written;
      logic [3:0] top;
      logic [3:0] bottom;
   } blit_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = REQ_WRITE;
   logic        req_first_pixel = 1'b0;
   logic signed [8:0] req_sprite_x = '0;
   logic signed [8:0] req_sprite_y = '0;
   logic [6:0]  req_sprite_w = '0;
   logic [6:0]  req_sprite_h = '0;
   logic        req_mirror_h = 1'b0;
   logic        req_mirror_v = 1'b0;
   logic [3:0]  req_pixel_color = '0;
   logic [12:0] req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_written;
   logic [3:0]  rsp_top_color;
   logic [3:0]  rsp_bottom_color;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;

   sprite_blit_halfblock_framebuffer DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_first_pixel  (req_first_pixel),
      .req_sprite_x     (req_sprite_x),
      .req_sprite_y     (req_sprite_y),
      .req_sprite_w     (req_sprite_w),
      .req_sprite_h     (req_sprite_h),
      .req_mirror_h     (req_mirror_h),
      .req_mirror_v     (req_mirror_v),
      .req_pixel_color  (req_pixel_color),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_written      (rsp_written),
      .rsp_top_color    (rsp_top_color),
      .rsp_bottom_color (rsp_bottom_color),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Requests waiting to be sent; the head is the one on the request ports.
   blit_req_type req_backlog[$];
   // Results predicted for accepted requests, oldest first.
   blit_rsp_type rsp_due[$];

   // Predictor state: a private copy of the framebuffer, the pixel counters,
   // the latched sprite geometry and the transparent key.
   logic [7:0]   fb_cells [0:CELL_COUNT-1];
   logic [5:0]   col_pos;
   logic [5:0]   row_pos;
   geometry_type sprite_geo;
   logic [3:0]   clear_key;

   int  items_queued   = 0;
   int  accepted_count = 0;
   int  result_count   = 0;
   int  fail_count     = 0;
   int  pixel_count    = 0;
   int  stored_count   = 0;
   int  read_count     = 0;
   int  sprite_count   = 0;
   int  key_writes     = 0;
   int  cycle_count    = 0;
   int  gap_left       = 0;
   bit  gaps_on        = 1'b1;
   bit  quiet          = 1'b0;

   function automatic int sprite_extent(input logic [6:0] s);
      if (s == 7'd0) return 1;
      if (int'(s) > MAX_SPRITE) return MAX_SPRITE;
      return int'(s);
   endfunction

   // Applies one accepted request to the predictor and returns the result the
   // block must produce for it.
   task automatic paint_and_predict(input blit_req_type r, output blit_rsp_type e);
      int w_ext;
      int h_ext;
      int col;
      int row;
      int px;
      int py;
      int cell_no;
      e = '{written: 1'b0, top: 4'h0, bottom: 4'h0};
      if (r.kind == REQ_READ) begin
         read_count++;
         // A read never disturbs the counters or the latched geometry.
         if (int'(r.index) < CELL_COUNT) begin
            e.top    = fb_cells[r.index][7:4];
            e.bottom = fb_cells[r.index][3:0];
         end
         return;
      end
      pixel_count++;
      if (r.first) begin
         sprite_geo.x  = r.x;
         sprite_geo.y  = r.y;
         sprite_geo.w  = r.w;
         sprite_geo.h  = r.h;
         sprite_geo.mh = r.mh;
         sprite_geo.mv = r.mv;
         col_pos = '0;
         row_pos = '0;
         sprite_count++;
      end
      w_ext = sprite_extent(sprite_geo.w);
      h_ext = sprite_extent(sprite_geo.h);
      col = int'(col_pos);
      row = int'(row_pos);
      if (col >= w_ext) col = 0;
      if (row >= h_ext) row = 0;
      px = int'(sprite_geo.x) + (sprite_geo.mh ? (w_ext - 1 - col) : col);
      py = int'(sprite_geo.y) + (sprite_geo.mv ? (h_ext - 1 - row) : row);
      if (r.color != clear_key && px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
         cell_no = px + SCREEN_W * (py / 2);
         if (cell_no < CELL_COUNT) begin
            // Even rows live in the high nibble, odd rows in the low one.
            if (py % 2 == 1) fb_cells[cell_no][3:0] = r.color;
            else fb_cells[cell_no][7:4] = r.color;
            e.written = 1'b1;
            stored_count++;
         end
      end
      // Counters run on for every pixel, stored or not, and wrap at the sprite's edges.
      col++;
      if (col >= w_ext) begin
         col = 0;
         row++;
         if (row >= h_ext) row = 0;
      end
      col_pos = 6'(col);
      row_pos = 6'(row);
   endtask

   function automatic blit_req_type random_req();
      blit_req_type r;
      r.kind  = 1'($urandom_range(0, 1));
      r.first = 1'($urandom_range(0, 1));
      r.x     = 9'($urandom);
      r.y     = 9'($urandom);
      r.w     = 7'($urandom);
      r.h     = 7'($urandom);
      r.mh    = 1'($urandom_range(0, 1));
      r.mv    = 1'($urandom_range(0, 1));
      r.color = 4'($urandom);
      r.index = 13'($urandom);
      return r;
   endfunction

   function automatic blit_req_type sprite_start(input int x, input int y, input int w,
                                                 input int h, input bit mh, input bit mv,
                                                 input int color);
      blit_req_type r;
      r       = random_req();
      r.kind  = REQ_WRITE;
      r.first = 1'b1;
      r.x     = 9'(x);
      r.y     = 9'(y);
      r.w     = 7'(w);
      r.h     = 7'(h);
      r.mh    = mh;
      r.mv    = mv;
      r.color = 4'(color);
      return r;
   endfunction

   // Later pixels of a sprite carry random geometry, which the block must ignore.
   function automatic blit_req_type next_pixel(input int color);
      blit_req_type r;
      r       = random_req();
      r.kind  = REQ_WRITE;
      r.first = 1'b0;
      r.color = 4'(color);
      return r;
   endfunction

   function automatic blit_req_type cell_read(input int index);
      blit_req_type r;
      r       = random_req();
      r.kind  = REQ_READ;
      r.index = 13'(index);
      return r;
   endfunction

   function automatic void enqueue(input blit_req_type r);
      req_backlog.push_back(r);
      items_queued++;
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("ERROR at %0t: %s", $realtime, what);
   endfunction

   // One burst of random stimulus. Most bursts are sprites with reads of
   // cells they touch mixed in; the rest are loose reads and pure noise.
   task automatic queue_random_chunk();
      blit_req_type r;
      int pick;
      int gx;
      int gy;
      int w_ext;
      int h_ext;
      int npix;
      int cx;
      int cy;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         r = sprite_start(0, 0, 1, 1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 15));
         // Mostly small sprites; a few hit the size extremes but stay short in pixels.
         case ($urandom_range(0, 19))
            0: begin
               r.w = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
               r.h = 7'($urandom_range(0, 2));
            end
            1: begin
               r.w = 7'($urandom_range(1, 3));
               r.h = 7'($urandom_range(60, 127));
            end
            2: begin
               r.w = 7'($urandom_range(33, 64));
               r.h = 7'd1;
            end
            default: begin
               r.w = 7'($urandom_range(1, 8));
               r.h = 7'($urandom_range(1, 8));
            end
         endcase
         if ($urandom_range(0, 9) == 0) r.x = 9'($urandom);
         else r.x = 9'(int'($urandom_range(0, 160)) - 16);
         if ($urandom_range(0, 9) == 0) r.y = 9'($urandom);
         else r.y = 9'(int'($urandom_range(0, 160)) - 16);
         gx    = int'(r.x);
         gy    = int'(r.y);
         w_ext = sprite_extent(r.w);
         h_ext = sprite_extent(r.h);
         npix  = w_ext * h_ext;
         // Sometimes run past the end to see the counters wrap, sometimes stop short.
         case ($urandom_range(0, 9))
            0: npix += $urandom_range(1, npix);
            1: npix = $urandom_range(1, npix);
            default: ;
         endcase
         for (int i = 0; i < npix; i++) begin
            if (i > 0) r = next_pixel($urandom_range(0, 15));
            enqueue(r);
            if ($urandom_range(0, 6) == 0) begin
               cx = gx + int'($urandom_range(0, w_ext - 1));
               cy = gy + int'($urandom_range(0, h_ext - 1));
               if (cx >= 0 && cx < SCREEN_W && cy >= 0 && cy < SCREEN_H)
                  enqueue(cell_read(cx + SCREEN_W * (cy / 2)));
               else
                  enqueue(cell_read($urandom_range(0, CELL_COUNT - 1)));
            end
         end
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) enqueue(cell_read($urandom_range(0, 8191)));
      end else begin
         enqueue(random_req());
      end
   endtask

   task automatic queue_random(input int count);
      int goal;
      goal = items_queued + count;
      while (items_queued < goal) queue_random_chunk();
   endtask

   // Writes the transparent key and mirrors it into the predictor once the
   // transfer has happened. Called just after a rising edge.
   task automatic write_key(input logic [3:0] k);
      csr_valid <= 1'b1;
      csr_data  <= k;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      clear_key = k;
      key_writes++;
   endtask

   // Waits until every request has been sent and answered. Every request yields
   // a result in the cycle after its transfer, so a short pause then leaves the block idle.
   task automatic wait_for_idle();
      while (req_backlog.size() != 0 || rsp_due.size() != 0 || start) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Request driver. The head of the backlog stays on the ports until a
   // transfer takes it; only then is a random gap possibly inserted.
   always @(posedge clock) begin : drive_requests
      blit_req_type taken;
      blit_rsp_type due;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            taken = req_backlog.pop_front();
            paint_and_predict(taken, due);
            rsp_due.push_back(due);
            accepted_count++;
            // Toggle now and then between bursty and steady stretches.
            if ($urandom_range(0, 49) == 0) quiet = !quiet;
            if (gaps_on && !quiet && $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(1, 11);
         end
         // A request stalled by busy must stay put, so nothing changes then.
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               start           <= 1'b1;
               req_type        <= req_backlog[0].kind;
               req_first_pixel <= req_backlog[0].first;
               req_sprite_x    <= req_backlog[0].x;
               req_sprite_y    <= req_backlog[0].y;
               req_sprite_w    <= req_backlog[0].w;
               req_sprite_h    <= req_backlog[0].h;
               req_mirror_h    <= req_backlog[0].mh;
               req_mirror_v    <= req_backlog[0].mv;
               req_pixel_color <= req_backlog[0].color;
               req_read_index  <= req_backlog[0].index;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor. The strobe lasts one cycle and cannot be held off, so each
   // strobed cycle is one result transfer, compared against the oldest prediction.
   always @(posedge clock) begin : check_results
      blit_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         result_count++;
         if (rsp_due.size() == 0) begin
            note_failure($sformatf("result with nothing pending: written=%0b top=%0h bottom=%0h",
                                   rsp_written, rsp_top_color, rsp_bottom_color));
         end else begin
            want = rsp_due.pop_front();
            if (rsp_written !== want.written || rsp_top_color !== want.top ||
                rsp_bottom_color !== want.bottom)
               note_failure($sformatf(
                  "result %0d: expected written=%0b top=%0h bottom=%0h, got %0b %0h %0h",
                  result_count, want.written, want.top, want.bottom,
                  rsp_written, rsp_top_color, rsp_bottom_color));
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d requests and %0d results outstanding.",
                  cycle_count, req_backlog.size(), rsp_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      foreach (fb_cells[i]) fb_cells[i] = 8'h00;
      col_pos    = '0;
      row_pos    = '0;
      sprite_geo = '0;
      clear_key  = 4'h0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The block is still clearing its memory here, but the key register takes
      // writes throughout, so the first setting goes in right away.
      write_key(4'hF);

      // A pixel before any first pixel uses the reset geometry, whose zero size
      // behaves as one: it lands on the top-left pixel. The second is transparent.
      enqueue(next_pixel(5));
      enqueue(next_pixel(15));
      enqueue(cell_read(0));
      // A read with the first-pixel flag set must not latch anything.
      begin : read_with_junk
         blit_req_type r;
         r = cell_read(8191);
         r.first = 1'b1;
         enqueue(r);
      end
      // Sprites parked at the far corners of the position range are fully off-screen.
      enqueue(sprite_start(-256, -256, 1, 1, 1'b0, 1'b0, 3));
      enqueue(sprite_start(255, 255, 64, 64, 1'b1, 1'b1, 9));
      // A 2x2 sprite at the bottom-right, mirrored both ways, fills the last two cells;
      // a fifth pixel wraps back to the first position.
      enqueue(sprite_start(126, 126, 2, 2, 1'b1, 1'b1, 1));
      enqueue(next_pixel(2));
      enqueue(next_pixel(3));
      enqueue(next_pixel(4));
      enqueue(cell_read(8191));
      enqueue(cell_read(8190));
      enqueue(next_pixel(6));
      // Zero width and height act as one, so every pixel rewrites the same spot.
      enqueue(sprite_start(10, 11, 0, 0, 1'b0, 1'b0, 7));
      enqueue(next_pixel(8));
      enqueue(cell_read(10 + SCREEN_W * 5));
      // Oversize dimensions clamp to the sprite limit; mirrored left to right.
      enqueue(sprite_start(0, 0, 127, 127, 1'b1, 1'b0, 12));
      enqueue(next_pixel(13));
      enqueue(cell_read(63));
      // A sprite hanging off the top-left edge.
      enqueue(sprite_start(-1, -1, 3, 3, 1'b0, 1'b1, 14));
      enqueue(next_pixel(10));
      enqueue(cell_read(0));
      wait_for_idle();

      // Color 0 as the key, then a random middle value, then back to 15 with the
      // sender running flat out for the last stretch.
      write_key(4'h0);
      queue_random(440);
      wait_for_idle();

      write_key(4'($urandom_range(1, 14)));
      queue_random(440);
      wait_for_idle();

      gaps_on = 1'b0;
      write_key(4'hF);
      queue_random(440);
      wait_for_idle();
      repeat (4) @(posedge clock);

      $display("Covered %0d transfers: %0d sprite pixels (%0d stored) in %0d sprites, %0d reads.",
               accepted_count, pixel_count, stored_count, sprite_count, read_count);
      $display("Transparent key was set %0d times; %0d results checked, %0d problems found.",
               key_writes, result_count, fail_count);
      if (fail_count == 0 && rsp_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
